[design/scs_pkg.sv]
// ----------------------------------------------------------------------------
// scs_pkg: shared types and constants of the session connect sequencer
// Beat payload structs, field widths, register indexes and reset values.
// ----------------------------------------------------------------------------
package scs_pkg;

    localparam int OP_W      = 4;
    localparam int EC_W      = 2;
    localparam int STATE_W   = 4;
    localparam int CMD_W     = 4;
    localparam int RETRY_W   = 8;
    localparam int COUNT_W   = 32;
    localparam int MS_W      = 16;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_W     = 16;

    localparam int BACKOFF_CAP_DEF = 6;
    localparam int TICKS_PER_SEC   = 1000;

    localparam logic [CFG_W-1:0] CONNECT_WAIT_MAX_RST = 16'd30000;
    localparam logic [CFG_W-1:0] RESPONSE_WAIT_RST    = 16'd5000;

    localparam logic [CFG_IDX_W-1:0] CFG_CONNECT_WAIT_MAX = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_RESPONSE_WAIT    = 1'b1;

    typedef struct packed {
        logic [OP_W-1:0] operation;
        logic [EC_W-1:0] error_class;
        logic            reply_rejected;
    } scs_in_t;

    typedef struct packed {
        logic [STATE_W-1:0] session_state;
        logic [STATE_W-1:0] previous_state;
        logic [CMD_W-1:0]   command;
        logic               apply_new_peer;
        logic               timer_fired;
        logic [RETRY_W-1:0] connect_attempts;
        logic [COUNT_W-1:0] response_timeouts;
        logic [COUNT_W-1:0] timeout_errors;
        logic [COUNT_W-1:0] polls_sent;
    } scs_out_t;

endpackage

[design/session_connect_sequencer.sv]
// ----------------------------------------------------------------------------
// session_connect_sequencer: client session sequencer top level
// Event beats in, one result beat (state, command, counters) out per event.
// ----------------------------------------------------------------------------
// Usage:
//   s_valid/s_ready/s_data carry completion events and 1 ms ticks; each
//   accepted beat yields exactly one m_valid/m_ready/m_data result beat.
//   cfg_we/cfg_index/cfg_wdata write the backoff limit (index 0) and the
//   response timeout (index 1); write only while idle.
// Path: an accepted event is held in the input register and then applied
//   into the result register, where its result beat is presented; a held
//   result beat can keep the event waiting in the input register.
// Throughput: one event per cycle while results are taken, set by the state
//   update from the input register into the state and result registers.
// Stalls: when m_ready is low the result register holds its beat; the input
//   register takes one more event if it is empty, then s_ready drops until
//   the result is taken.
// Reset: aresetn low clears the state to idle, stops both timers, zeroes the
//   counters and reloads the register defaults; no beats are pending after.
// ----------------------------------------------------------------------------
module session_connect_sequencer import scs_pkg::*; #(
    parameter int BACKOFF_CAP = BACKOFF_CAP_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wdata,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  scs_in_t              s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output scs_out_t             m_data
);

    // event beat held for the core
    logic    in_valid;
    scs_in_t in_data;
    // core can absorb the held beat this cycle
    logic    core_ready;

    scs_in_stage u_in_stage (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .in_valid   (in_valid),
        .in_data    (in_data),
        .core_ready (core_ready)
    );

    // state machine, timers and counters; registers the result beat
    scs_core #(
        .BACKOFF_CAP (BACKOFF_CAP)
    ) u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .in_valid   (in_valid),
        .in_data    (in_data),
        .core_ready (core_ready),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data)
    );

endmodule

[design/scs_in_stage.sv]
// ----------------------------------------------------------------------------
// scs_in_stage: input register of the session connect sequencer
// Captures one event beat and holds it until the core consumes it.
// ----------------------------------------------------------------------------
module scs_in_stage import scs_pkg::*; (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_valid,
    output logic    s_ready,
    input  scs_in_t s_data,
    output logic    in_valid,
    output scs_in_t in_data,
    input  logic    core_ready
);

    logic    valid_reg;
    scs_in_t data_reg;

    assign s_ready  = !valid_reg || core_ready;
    assign in_valid = valid_reg;
    assign in_data  = data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_ready) begin
            valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            data_reg <= s_data;
        end
    end

endmodule

[design/scs_core.sv]
// ----------------------------------------------------------------------------
// scs_core: session state machine, timers, counters and result register
// Applies one event beat per cycle unless a held result beat stalls it, and registers the result beat.
// ----------------------------------------------------------------------------
module scs_core import scs_pkg::*; #(
    parameter int BACKOFF_CAP = BACKOFF_CAP_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wdata,
    input  logic                 in_valid,
    input  scs_in_t              in_data,
    output logic                 core_ready,
    output logic                 m_valid,
    input  logic                 m_ready,
    output scs_out_t             m_data
);

    typedef enum logic [STATE_W-1:0] {
        ST_IDLE      = 4'd0,
        ST_RESOLVE   = 4'd1,
        ST_CONN1     = 4'd2,
        ST_HS1       = 4'd3,
        ST_SENDNS    = 4'd4,
        ST_NSWAIT    = 4'd5,
        ST_SENDSUB   = 4'd6,
        ST_SUBWAIT   = 4'd7,
        ST_CONN2     = 4'd8,
        ST_HS2       = 4'd9,
        ST_SENDPOLL  = 4'd10,
        ST_POLLWAIT  = 4'd11,
        ST_RESTART   = 4'd12,
        ST_RETRYWAIT = 4'd13
    } state_t;

    localparam logic [OP_W-1:0] OP_START   = 4'd0;
    localparam logic [OP_W-1:0] OP_RESOLVE = 4'd1;
    localparam logic [OP_W-1:0] OP_CONNECT = 4'd2;
    localparam logic [OP_W-1:0] OP_HSHAKE  = 4'd3;
    localparam logic [OP_W-1:0] OP_WRITE   = 4'd4;
    localparam logic [OP_W-1:0] OP_READ    = 4'd5;
    localparam logic [OP_W-1:0] OP_CHUNK   = 4'd6;
    localparam logic [OP_W-1:0] OP_CLEANED = 4'd7;
    localparam logic [OP_W-1:0] OP_PEER    = 4'd8;
    localparam logic [OP_W-1:0] OP_TICK    = 4'd9;

    localparam logic [EC_W-1:0] EC_OK      = 2'd0;
    localparam logic [EC_W-1:0] EC_ABORTED = 2'd1;
    localparam logic [EC_W-1:0] EC_TIMEOUT = 2'd2;

    localparam logic [CMD_W-1:0] CMD_NONE    = 4'd0;
    localparam logic [CMD_W-1:0] CMD_FORWARD = 4'd13;

    // 1000 ms scaled by up to 2^BACKOFF_CAP, compared against a 16-bit limit
    localparam int BO_W  = $clog2(TICKS_PER_SEC) + BACKOFF_CAP;
    localparam int CMP_W = (BO_W > MS_W) ? BO_W : MS_W;
    localparam logic [RETRY_W-1:0] CAP_R     = RETRY_W'(BACKOFF_CAP);
    localparam logic [RETRY_W-1:0] RETRY_MAX = {RETRY_W{1'b1}};

    function automatic logic is_timed(state_t s);
        return s == ST_RESOLVE || s == ST_CONN1 || s == ST_HS1 || s == ST_NSWAIT ||
               s == ST_SUBWAIT || s == ST_CONN2 || s == ST_HS2;
    endfunction

    logic [CFG_W-1:0]   conn_max_reg, resp_wait_reg;
    state_t             state_reg, state_next;
    state_t             last_reg, last_next;
    logic [RETRY_W-1:0] retry_reg, retry_next;
    logic [MS_W-1:0]    conn_tmr_reg, conn_tmr_next;
    logic               conn_on_reg, conn_on_next;
    logic [MS_W-1:0]    resp_tmr_reg, resp_tmr_next;
    logic               resp_on_reg, resp_on_next;
    logic [COUNT_W-1:0] expiry_reg, expiry_next;
    logic [COUNT_W-1:0] tmo_reg, tmo_next;
    logic [COUNT_W-1:0] poll_reg, poll_next;
    logic               out_valid_reg;
    scs_out_t           out_reg;

    logic               fire;
    logic               ok, is_done, enter_en, peer, fired;
    state_t             enter_s;
    logic [CMD_W-1:0]   cmd;
    logic [RETRY_W-1:0] bo_sel;
    logic [CMP_W-1:0]   bo_ms;
    logic [MS_W-1:0]    backoff;

    assign core_ready = !out_valid_reg || m_ready;
    assign fire       = in_valid && core_ready;
    assign m_valid    = out_valid_reg;
    assign m_data     = out_reg;

    // retry backoff: min(1000 << min(attempts, cap), limit)
    always_comb begin
        bo_sel = (retry_reg < CAP_R) ? retry_reg : CAP_R;
        bo_ms  = CMP_W'(TICKS_PER_SEC) << bo_sel;
        if (bo_ms < CMP_W'(conn_max_reg)) begin
            backoff = bo_ms[MS_W-1:0];
        end else begin
            backoff = conn_max_reg;
        end
    end

    always_comb begin
        state_next    = state_reg;
        last_next     = last_reg;
        retry_next    = retry_reg;
        conn_tmr_next = conn_tmr_reg;
        conn_on_next  = conn_on_reg;
        resp_tmr_next = resp_tmr_reg;
        resp_on_next  = resp_on_reg;
        expiry_next   = expiry_reg;
        tmo_next      = tmo_reg;
        poll_next     = poll_reg;
        cmd           = CMD_NONE;
        peer          = 1'b0;
        fired         = 1'b0;
        enter_en      = 1'b0;
        enter_s       = ST_RESTART;

        ok      = in_data.error_class == EC_OK;
        is_done = in_data.operation >= OP_RESOLVE && in_data.operation <= OP_CHUNK;

        if (is_done && in_data.error_class == EC_TIMEOUT) begin
            tmo_next = tmo_reg + COUNT_W'(1);
        end

        // drop aborted completions entirely
        if (!(is_done && in_data.error_class == EC_ABORTED)) begin
            unique case (in_data.operation)
                OP_START: begin
                    if (state_reg == ST_IDLE) begin
                        enter_en = 1'b1;
                        enter_s  = ST_RESOLVE;
                    end
                end
                OP_RESOLVE: begin
                    if (state_reg == ST_RESOLVE) begin
                        enter_en = 1'b1;
                        enter_s  = ok ? ST_CONN1 : ST_RESTART;
                    end
                end
                OP_CONNECT: begin
                    if (state_reg == ST_CONN1) begin
                        enter_en = 1'b1;
                        enter_s  = ok ? ST_HS1 : ST_RESTART;
                        if (ok) begin
                            retry_next = '0;
                        end
                    end else if (state_reg == ST_CONN2) begin
                        enter_en = 1'b1;
                        enter_s  = ok ? ST_HS2 : ST_RESTART;
                    end
                end
                OP_HSHAKE: begin
                    if (state_reg == ST_HS1) begin
                        enter_en = 1'b1;
                        enter_s  = ok ? ST_SENDNS : ST_RESTART;
                    end else if (state_reg == ST_HS2) begin
                        enter_en = 1'b1;
                        enter_s  = ok ? ST_SENDPOLL : ST_RESTART;
                    end
                end
                OP_WRITE: begin
                    if (state_reg == ST_SENDNS || state_reg == ST_SENDSUB ||
                        state_reg == ST_SENDPOLL) begin
                        enter_en = 1'b1;
                        enter_s  = ok ? state_t'(state_reg + STATE_W'(1)) : ST_RESTART;
                        if (ok && state_reg == ST_SENDPOLL) begin
                            poll_next = poll_reg + COUNT_W'(1);
                        end
                    end
                end
                OP_READ: begin
                    if (state_reg == ST_NSWAIT || state_reg == ST_SUBWAIT ||
                        state_reg == ST_POLLWAIT) begin
                        enter_en = 1'b1;
                        if (!ok || in_data.reply_rejected) begin
                            enter_s = ST_RESTART;
                        end else if (state_reg == ST_POLLWAIT) begin
                            enter_s = ST_SENDPOLL;
                        end else begin
                            enter_s = state_t'(state_reg + STATE_W'(1));
                        end
                    end
                end
                OP_CHUNK: begin
                    if (state_reg == ST_NSWAIT || state_reg == ST_SUBWAIT ||
                        state_reg == ST_POLLWAIT) begin
                        if (ok) begin
                            cmd = CMD_FORWARD;
                        end else begin
                            enter_en = 1'b1;
                            enter_s  = ST_RESTART;
                        end
                    end
                end
                OP_CLEANED: begin
                    if (state_reg == ST_RESTART) begin
                        enter_en = 1'b1;
                        enter_s  = ST_RETRYWAIT;
                    end
                end
                OP_PEER: begin
                    if (state_reg != ST_IDLE) begin
                        peer = 1'b1;
                        if (state_reg != ST_RESTART) begin
                            enter_en = 1'b1;
                            enter_s  = ST_RESTART;
                        end
                    end
                end
                OP_TICK: begin
                    // at most one timer runs at a time
                    if (resp_on_reg) begin
                        if (resp_tmr_reg <= MS_W'(1)) begin
                            resp_tmr_next = '0;
                            resp_on_next  = 1'b0;
                            fired         = 1'b1;
                            expiry_next   = expiry_reg + COUNT_W'(1);
                            if (is_timed(state_reg)) begin
                                enter_en = 1'b1;
                                enter_s  = ST_RESTART;
                            end
                        end else begin
                            resp_tmr_next = resp_tmr_reg - MS_W'(1);
                        end
                    end else if (conn_on_reg) begin
                        if (conn_tmr_reg <= MS_W'(1)) begin
                            conn_tmr_next = '0;
                            conn_on_next  = 1'b0;
                            fired         = 1'b1;
                            if (state_reg == ST_RETRYWAIT) begin
                                enter_en = 1'b1;
                                enter_s  = ST_RESOLVE;
                            end
                        end else begin
                            conn_tmr_next = conn_tmr_reg - MS_W'(1);
                        end
                    end
                end
                default: begin
                end
            endcase
        end

        // state entry: stop both timers, then run the entry action
        if (enter_en) begin
            last_next    = state_reg;
            state_next   = enter_s;
            resp_on_next = 1'b0;
            conn_on_next = 1'b0;
            if (enter_s == ST_RETRYWAIT) begin
                cmd           = CMD_NONE;
                conn_tmr_next = backoff;
                conn_on_next  = 1'b1;
                if (retry_reg != RETRY_MAX) begin
                    retry_next = retry_reg + RETRY_W'(1);
                end
            end else begin
                cmd = CMD_W'(enter_s);
                if (is_timed(enter_s)) begin
                    resp_tmr_next = resp_wait_reg;
                    resp_on_next  = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            conn_max_reg  <= CONNECT_WAIT_MAX_RST;
            resp_wait_reg <= RESPONSE_WAIT_RST;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_CONNECT_WAIT_MAX: conn_max_reg  <= cfg_wdata;
                CFG_RESPONSE_WAIT:    resp_wait_reg <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            last_reg      <= ST_IDLE;
            retry_reg     <= '0;
            conn_tmr_reg  <= '0;
            conn_on_reg   <= 1'b0;
            resp_tmr_reg  <= '0;
            resp_on_reg   <= 1'b0;
            expiry_reg    <= '0;
            tmo_reg       <= '0;
            poll_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (fire) begin
                state_reg     <= state_next;
                last_reg      <= last_next;
                retry_reg     <= retry_next;
                conn_tmr_reg  <= conn_tmr_next;
                conn_on_reg   <= conn_on_next;
                resp_tmr_reg  <= resp_tmr_next;
                resp_on_reg   <= resp_on_next;
                expiry_reg    <= expiry_next;
                tmo_reg       <= tmo_next;
                poll_reg      <= poll_next;
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            out_reg.session_state     <= state_next;
            out_reg.previous_state    <= last_next;
            out_reg.command           <= cmd;
            out_reg.apply_new_peer    <= peer;
            out_reg.timer_fired       <= fired;
            out_reg.connect_attempts  <= retry_next;
            out_reg.response_timeouts <= expiry_next;
            out_reg.timeout_errors    <= tmo_next;
            out_reg.polls_sent        <= poll_next;
        end
    end

`ifndef SYNTHESIS
    a_one_timer: assert property (@(posedge aclk) disable iff (!aresetn)
        !(resp_on_reg && conn_on_reg))
        else $error("response and connect timers running together");

    a_resp_timed: assert property (@(posedge aclk) disable iff (!aresetn)
        resp_on_reg |-> is_timed(state_reg))
        else $error("response timer running outside a waiting state");

    a_conn_retry: assert property (@(posedge aclk) disable iff (!aresetn)
        conn_on_reg |-> state_reg == ST_RETRYWAIT)
        else $error("connect timer running outside retry wait");

    a_out_state: assert property (@(posedge aclk) disable iff (!aresetn)
        fire |=> m_valid && m_data.session_state == state_reg &&
                 m_data.connect_attempts == retry_reg)
        else $error("result beat disagrees with held state");
`endif

endmodule
